/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ECS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecs check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ECS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecs check failed");

`endif

/* sv/ecs_pkg.sv */
// ----------------------------------------------------------------------------
// ecs_pkg
// types, constants and helpers of the sensor compensation pipeline
// ----------------------------------------------------------------------------
package ecs_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_CAL_MISC    = 3'd3,
    REG_CAL_HUM     = 3'd4
  } cfg_reg_t;

  // pipeline stage map
  localparam int FINE_STAGE = 4;   // fine temperature registered
  localparam int TEMP_STAGE = 6;   // temperature result registered
  localparam int HUM_STAGE  = 14;  // humidity result registered
  localparam int RAWP_USE   = 9;   // stage whose raw pressure feeds the dividend
  localparam int LATENCY    = 47;  // output register stage

  // result limits
  localparam logic [31:0] TEMP_MIN  = 32'hFFFF_F060;  // -4000
  localparam logic [31:0] TEMP_MAX  = 32'd8500;
  localparam logic [31:0] PRESS_MIN = 32'd30000;
  localparam logic [31:0] PRESS_MAX = 32'd110000;
  localparam logic [31:0] HUM_E_MAX = 32'd419430400;
  localparam logic [31:0] HUM_MAX   = 32'd102400;

  // calibration coefficients, each widened to 32 bits
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } cal_t;

  // signed divide by 2**k, rounding toward zero
  function automatic logic [31:0] sdiv_p2(input logic [31:0] x, input logic [4:0] k);
    logic [31:0] bias;
    bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return 32'($signed(x + bias) >>> k);
  endfunction

  // 32-bit wrapping product
  function automatic logic [31:0] wmul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

/* sv/ecs_delay.sv */
// ----------------------------------------------------------------------------
// ecs_delay
// fixed-length shift line that moves with the pipeline advance
// ----------------------------------------------------------------------------
module ecs_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [0:DEPTH-1];

  // shift on every advance
  always_ff @(posedge clk) begin
    if (adv) begin
      tap_r[0] <= din;
      for (int i = 1; i < DEPTH; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

/* sv/ecs_temp.sv */
// ----------------------------------------------------------------------------
// ecs_temp
// fine temperature (stages 1-4) and clamped temperature (stages 5-6)
// ----------------------------------------------------------------------------
module ecs_temp import ecs_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  cal_t        cal,
  input  logic [19:0] raw_t,
  output logic [31:0] fine,
  output logic [14:0] temp
);

  logic [31:0] a0_r, b0_r, am_r, bm_r, a1_r, bm2_r, fine_r, tm_r;
  logic [14:0] temp_r;
  logic [31:0] a0_nxt, b0_nxt, am_nxt, bm_nxt, a1_nxt, bm2_nxt, fine_nxt, tm_nxt, tr;
  logic [14:0] temp_nxt;

  // stage logic
  always_comb begin
    a0_nxt   = {15'd0, raw_t[19:3]} - {cal.t1[30:0], 1'b0};
    b0_nxt   = {16'd0, raw_t[19:4]} - cal.t1;
    am_nxt   = wmul(a0_r, cal.t2);
    bm_nxt   = wmul(b0_r, b0_r);
    a1_nxt   = sdiv_p2(am_r, 5'd11);
    bm2_nxt  = wmul(sdiv_p2(bm_r, 5'd12), cal.t3);
    fine_nxt = a1_r + sdiv_p2(bm2_r, 5'd14);
    tm_nxt   = wmul(fine_r, 32'd5);
    tr       = sdiv_p2(tm_r + 32'd128, 5'd8);
    if ($signed(tr) < $signed(TEMP_MIN)) tr = TEMP_MIN;
    else if ($signed(tr) > $signed(TEMP_MAX)) tr = TEMP_MAX;
    temp_nxt = tr[14:0];
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a0_r   <= a0_nxt;
      b0_r   <= b0_nxt;
      am_r   <= am_nxt;
      bm_r   <= bm_nxt;
      a1_r   <= a1_nxt;
      bm2_r  <= bm2_nxt;
      fine_r <= fine_nxt;
      tm_r   <= tm_nxt;
      temp_r <= temp_nxt;
    end
  end

  assign fine = fine_r;
  assign temp = temp_r;

endmodule

/* sv/ecs_hum.sv */
// ----------------------------------------------------------------------------
// ecs_hum
// humidity compensation, ten stages after the fine temperature
// ----------------------------------------------------------------------------
module ecs_hum import ecs_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  cal_t        cal,
  input  logic [31:0] fine,
  input  logic [15:0] raw_h,
  output logic [16:0] hum
);

  logic [31:0] a1_r, bc1_r, d2_r, b2_r, c2_r, bc2_r, e3_r, b3_r, c3_r;
  logic [31:0] m4_r, e4_r, dd5_r, e5_r, b6_r, e6_r, c7_r, c8_r, d8_r, c9_r, m9_r;
  logic [16:0] hum_r;
  logic [31:0] a1_nxt, bc1_nxt, d2_nxt, b2_nxt, c2_nxt, e3_nxt, b3_nxt, c3_nxt;
  logic [31:0] m4_nxt, dd5_nxt, b6_nxt, c7_nxt, c8q, d8_nxt, m9_nxt, e10;
  logic [16:0] hum_nxt;

  // stage logic
  always_comb begin
    a1_nxt  = fine - 32'd76800;
    bc1_nxt = {2'd0, raw_h, 14'd0} - {cal.h4[11:0], 20'd0};
    d2_nxt  = wmul(cal.h5, a1_r);
    b2_nxt  = wmul(a1_r, cal.h6);
    c2_nxt  = wmul(a1_r, cal.h3);
    e3_nxt  = sdiv_p2(bc2_r - d2_r + 32'd16384, 5'd15);
    b3_nxt  = sdiv_p2(b2_r, 5'd10);
    c3_nxt  = sdiv_p2(c2_r, 5'd11) + 32'd32768;
    m4_nxt  = wmul(b3_r, c3_r);
    dd5_nxt = wmul(sdiv_p2(m4_r, 5'd10) + 32'd2097152, cal.h2);
    b6_nxt  = sdiv_p2(dd5_r + 32'd8192, 5'd14);
    c7_nxt  = wmul(e6_r, b6_r);
    c8q     = sdiv_p2(c7_r, 5'd15);
    d8_nxt  = wmul(c8q, c8q);
    m9_nxt  = wmul(sdiv_p2(d8_r, 5'd7), cal.h1);
    e10     = c9_r - sdiv_p2(m9_r, 5'd4);
    if (e10[31]) e10 = 32'd0;
    if (e10 > HUM_E_MAX) e10 = HUM_E_MAX;
    e10 = e10 >> 12;
    if (e10 > HUM_MAX) e10 = HUM_MAX;
    hum_nxt = e10[16:0];
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r  <= a1_nxt;
      bc1_r <= bc1_nxt;
      d2_r  <= d2_nxt;
      b2_r  <= b2_nxt;
      c2_r  <= c2_nxt;
      bc2_r <= bc1_r;
      e3_r  <= e3_nxt;
      b3_r  <= b3_nxt;
      c3_r  <= c3_nxt;
      m4_r  <= m4_nxt;
      e4_r  <= e3_r;
      dd5_r <= dd5_nxt;
      e5_r  <= e4_r;
      b6_r  <= b6_nxt;
      e6_r  <= e5_r;
      c7_r  <= c7_nxt;
      c8_r  <= c7_r;
      d8_r  <= d8_nxt;
      c9_r  <= c8_r;
      m9_r  <= m9_nxt;
      hum_r <= hum_nxt;
    end
  end

  assign hum = hum_r;

endmodule

/* sv/ecs_div.sv */
// ----------------------------------------------------------------------------
// ecs_div
// 32-stage unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ecs_div (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic [1:0]  side_in,
  output logic [31:0] quotient,
  output logic [1:0]  side_out
);

  logic [31:0] rem_r [0:31];
  logic [31:0] num_r [0:31];
  logic [31:0] dvs_r [0:31];
  logic [1:0]  side_r [0:31];

  // one shift-and-subtract step: {remainder, shifted numerator with quotient bit}
  function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] num,
                                           input logic [31:0] dvs);
    logic [32:0] sh;
    logic [33:0] tr;
    sh = {rem, num[31]};
    tr = {1'b0, sh} - {2'b00, dvs};
    if (!tr[33]) return {tr[31:0], num[30:0], 1'b1};
    return {sh[31:0], num[30:0], 1'b0};
  endfunction

  // divider stages
  always_ff @(posedge clk) begin
    if (adv) begin
      {rem_r[0], num_r[0]} <= div_step(32'd0, dividend, divisor);
      dvs_r[0]  <= divisor;
      side_r[0] <= side_in;
      for (int i = 1; i < 32; i++) begin
        {rem_r[i], num_r[i]} <= div_step(rem_r[i-1], num_r[i-1], dvs_r[i-1]);
        dvs_r[i]  <= dvs_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign quotient = num_r[31];
  assign side_out = side_r[31];

endmodule

/* sv/ecs_press.sv */
// ----------------------------------------------------------------------------
// ecs_press
// pressure: coefficient stages, pipelined divide and the final correction
// ----------------------------------------------------------------------------
module ecs_press import ecs_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  cal_t        cal,
  input  logic [31:0] fine,
  input  logic [19:0] raw_p,
  output logic [16:0] press
);

  logic [31:0] a1_r, aq1_r, sq2_r, m52_r, d02_r, b3_r, c3_r, m53_r, dh3_r, bb4_r, x4_r;
  logic [31:0] am5_r, bb5_r, dv6_r, u6_r, dv7_r, p07_r, dvd8_r, dvs8_r;
  logic [1:0]  side8_r, side45_r, side46_r;
  logic [31:0] pr45_r, sq45_r, m845_r, pr46_r, a46_r, b46_r;
  logic [16:0] press_r;
  logic [31:0] a1_nxt, aq1_nxt, sq2_nxt, m52_nxt, d02_nxt, b3_nxt, c3_nxt, bb4_nxt, x4_nxt;
  logic [31:0] am5_nxt, dv6_nxt, u6_nxt, p07_nxt, dvd8_nxt, pr45_nxt, sq45_nxt, m845_nxt;
  logic [31:0] a46_nxt, b46_nxt, pd8, pv;
  logic [16:0] press_nxt;
  logic [31:0] quot;
  logic [1:0]  side_q;

  // side bits: [1] dividend was divided before doubling, [0] divisor is zero
  always_comb begin
    a1_nxt   = sdiv_p2(fine, 5'd1) - 32'd64000;
    aq1_nxt  = sdiv_p2(a1_nxt, 5'd2);
    sq2_nxt  = wmul(aq1_r, aq1_r);
    m52_nxt  = wmul(a1_r, cal.p5);
    d02_nxt  = wmul(cal.p2, a1_r);
    b3_nxt   = wmul(sdiv_p2(sq2_r, 5'd11), cal.p6);
    c3_nxt   = wmul(cal.p3, sdiv_p2(sq2_r, 5'd13));
    bb4_nxt  = sdiv_p2(b3_r + m53_r, 5'd2) + {cal.p4[15:0], 16'd0};
    x4_nxt   = 32'd32768 + sdiv_p2(sdiv_p2(c3_r, 5'd3) + dh3_r, 5'd18);
    am5_nxt  = wmul(x4_r, cal.p1);
    dv6_nxt  = sdiv_p2(am5_r, 5'd15);
    u6_nxt   = (32'd1048576 - {12'd0, raw_p}) - sdiv_p2(bb5_r, 5'd12);
    p07_nxt  = wmul(u6_r, 32'd3125);
    dvd8_nxt = p07_r[31] ? p07_r : {p07_r[30:0], 1'b0};
    pr45_nxt = side_q[1] ? {quot[30:0], 1'b0} : quot;
    pd8      = pr45_nxt >> 3;
    sq45_nxt = wmul(pd8, pd8);
    m845_nxt = wmul(pr45_nxt >> 2, cal.p8);
    a46_nxt  = wmul(cal.p9, sq45_r >> 13);
    b46_nxt  = sdiv_p2(m845_r, 5'd13);
    pv       = pr46_r + sdiv_p2(sdiv_p2(a46_r, 5'd12) + b46_r + cal.p7, 5'd4);
    if (pv < PRESS_MIN) pv = PRESS_MIN;
    else if (pv > PRESS_MAX) pv = PRESS_MAX;
    if (side46_r[0]) pv = PRESS_MIN;
    press_nxt = pv[16:0];
  end

  // stages before and after the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_r     <= a1_nxt;
      aq1_r    <= aq1_nxt;
      sq2_r    <= sq2_nxt;
      m52_r    <= m52_nxt;
      d02_r    <= d02_nxt;
      b3_r     <= b3_nxt;
      c3_r     <= c3_nxt;
      m53_r    <= {m52_r[30:0], 1'b0};
      dh3_r    <= sdiv_p2(d02_r, 5'd1);
      bb4_r    <= bb4_nxt;
      x4_r     <= x4_nxt;
      am5_r    <= am5_nxt;
      bb5_r    <= bb4_r;
      dv6_r    <= dv6_nxt;
      u6_r     <= u6_nxt;
      dv7_r    <= dv6_r;
      p07_r    <= p07_nxt;
      dvd8_r   <= dvd8_nxt;
      dvs8_r   <= dv7_r;
      side8_r  <= {p07_r[31], dv7_r == 32'd0};
      pr45_r   <= pr45_nxt;
      sq45_r   <= sq45_nxt;
      m845_r   <= m845_nxt;
      side45_r <= side_q;
      pr46_r   <= pr45_r;
      a46_r    <= a46_nxt;
      b46_r    <= b46_nxt;
      side46_r <= side45_r;
      press_r  <= press_nxt;
    end
  end

  ecs_div u_div (
    .clk      (clk),
    .adv      (adv),
    .dividend (dvd8_r),
    .divisor  (dvs8_r),
    .side_in  (side8_r),
    .quotient (quot),
    .side_out (side_q)
  );

  assign press = press_r;

endmodule

/* sv/env_sensor_compensation.sv */
// each accepted input transaction yields its result on out_* in input order
// throughput: one transaction per cycle while out_* is not stalled; the pressure divider is a 32-stage pipeline
// a stalled output freezes every stage, so in_tready is high when out_tvalid is low or out_tready is high
// reset: synchronous active-low rst_n clears the valid line and calibration registers
// ----------------------------------------------------------------------------
// env_sensor_compensation
// temperature, pressure and humidity compensation of raw sensor samples
// ----------------------------------------------------------------------------
module env_sensor_compensation import ecs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb,
  //           hum_high, hum_low (8 bits each, from bit 0 up)
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // out_tdata: temperature_centi[14:0], pressure_pa[31:15], humidity_q10[48:32], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [47:0]        cal_temp_r, cal_misc_r;
  logic [63:0]        cal_press_a_r, cal_press_b_r;
  logic [31:0]        cal_hum_r;
  logic [LATENCY-1:0] vld_r;
  logic               adv;
  cal_t               cal;
  logic [19:0]        raw_t, raw_p, raw_p_d;
  logic [15:0]        raw_h, raw_h_d;
  logic [31:0]        fine;
  logic [14:0]        temp, temp_d;
  logic [16:0]        hum, hum_d, press;

  // whole pipeline moves together unless the output is stalled
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r    <= '0;
      cal_press_a_r <= '0;
      cal_press_b_r <= '0;
      cal_misc_r    <= '0;
      cal_hum_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAL_TEMP:    cal_temp_r    <= cfg_wdata[47:0];
        REG_CAL_PRESS_A: cal_press_a_r <= cfg_wdata;
        REG_CAL_PRESS_B: cal_press_b_r <= cfg_wdata;
        REG_CAL_MISC:    cal_misc_r    <= cfg_wdata[47:0];
        REG_CAL_HUM:     cal_hum_r     <= cfg_wdata[31:0];
        default:         ;
      endcase
    end
  end

  // coefficient unpacking
  always_comb begin
    cal.t1 = {16'd0, cal_temp_r[15:0]};
    cal.t2 = {{16{cal_temp_r[31]}}, cal_temp_r[31:16]};
    cal.t3 = {{16{cal_temp_r[47]}}, cal_temp_r[47:32]};
    cal.p1 = {16'd0, cal_press_a_r[15:0]};
    cal.p2 = {{16{cal_press_a_r[31]}}, cal_press_a_r[31:16]};
    cal.p3 = {{16{cal_press_a_r[47]}}, cal_press_a_r[47:32]};
    cal.p4 = {{16{cal_press_a_r[63]}}, cal_press_a_r[63:48]};
    cal.p5 = {{16{cal_press_b_r[15]}}, cal_press_b_r[15:0]};
    cal.p6 = {{16{cal_press_b_r[31]}}, cal_press_b_r[31:16]};
    cal.p7 = {{16{cal_press_b_r[47]}}, cal_press_b_r[47:32]};
    cal.p8 = {{16{cal_press_b_r[63]}}, cal_press_b_r[63:48]};
    cal.p9 = {{16{cal_misc_r[15]}}, cal_misc_r[15:0]};
    cal.h1 = {24'd0, cal_misc_r[23:16]};
    cal.h2 = {{16{cal_misc_r[39]}}, cal_misc_r[39:24]};
    cal.h3 = {24'd0, cal_misc_r[47:40]};
    cal.h4 = {{20{cal_hum_r[11]}}, cal_hum_r[11:0]};
    cal.h5 = {{20{cal_hum_r[23]}}, cal_hum_r[23:12]};
    cal.h6 = {{24{cal_hum_r[31]}}, cal_hum_r[31:24]};
  end

  // raw reading assembly
  assign raw_p = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:20]};
  assign raw_t = {in_tdata[31:24], in_tdata[39:32], in_tdata[47:44]};
  assign raw_h = {in_tdata[55:48], in_tdata[63:56]};

  // valid line alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LATENCY-2:0], in_tvalid};
    end
  end

  ecs_temp u_temp (
    .clk(clk), .adv(adv), .cal(cal), .raw_t(raw_t), .fine(fine), .temp(temp)
  );

  ecs_delay #(.WIDTH(20), .DEPTH(RAWP_USE)) u_rawp_dly (
    .clk(clk), .adv(adv), .din(raw_p), .dout(raw_p_d)
  );

  ecs_delay #(.WIDTH(16), .DEPTH(FINE_STAGE)) u_rawh_dly (
    .clk(clk), .adv(adv), .din(raw_h), .dout(raw_h_d)
  );

  ecs_press u_press (
    .clk(clk), .adv(adv), .cal(cal), .fine(fine), .raw_p(raw_p_d), .press(press)
  );

  ecs_hum u_hum (
    .clk(clk), .adv(adv), .cal(cal), .fine(fine), .raw_h(raw_h_d), .hum(hum)
  );

  // align temperature and humidity with the pressure output stage
  ecs_delay #(.WIDTH(15), .DEPTH(LATENCY - TEMP_STAGE)) u_temp_dly (
    .clk(clk), .adv(adv), .din(temp), .dout(temp_d)
  );

  ecs_delay #(.WIDTH(17), .DEPTH(LATENCY - HUM_STAGE)) u_hum_dly (
    .clk(clk), .adv(adv), .din(hum), .dout(hum_d)
  );

  assign out_tvalid = vld_r[LATENCY-1];
  assign out_tdata  = {7'd0, hum_d, press, temp_d};

endmodule

/* sv/ecs_checker.sv */
// ----------------------------------------------------------------------------
// ecs_checker
// port-level checks of the compensation block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        cfg_wr_en,
  input logic [2:0]  cfg_index,
  input logic [63:0] cfg_wdata
);

  // a pending result stays offered
  `ECS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // input side is open exactly when the output can move
  `ECS_ASSERT_IMPL(a_ready_link, 1'b1, in_tready == (!out_tvalid || out_tready))

  // temperature inside its clamp range
  `ECS_ASSERT_IMPL(a_temp_rng, out_tvalid,
    $signed(out_tdata[14:0]) >= -15'sd4000 && $signed(out_tdata[14:0]) <= 15'sd8500)

  // pressure inside its clamp range
  `ECS_ASSERT_IMPL(a_press_rng, out_tvalid,
    out_tdata[31:15] >= 17'd30000 && out_tdata[31:15] <= 17'd110000)

  // humidity at most full scale, padding zero
  `ECS_ASSERT_IMPL(a_hum_rng, out_tvalid,
    out_tdata[48:32] <= 17'd102400 && out_tdata[55:49] == 7'd0)

endmodule

bind env_sensor_compensation ecs_checker u_ecs_checker (.*);
